@@ hdl/assert_macros.svh @@
// assertion macros used by the top level rtl file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef NO_ASSERTIONS
// property checked every cycle outside reset
`define ASSERT_HOLDS(lbl, clk, rst_n, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
// condition in one cycle implies a consequence in the next
`define ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);
`else
`define ASSERT_HOLDS(lbl, clk, rst_n, prop, msg)
`define ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg)
`endif
`endif

@@ hdl/ppa_pkg.sv @@
// shared widths, register codes and types of the positional pid block
package ppa_pkg;

	// field widths
	localparam int IN_W   = 16;
	localparam int CFG_W  = 32;
	localparam int GAIN_W = 32;
	localparam int LIM_W  = 16;
	localparam int SUM_W  = 32;
	localparam int ERR_W  = 21;
	localparam int IDX_W  = 3;

	// error scaling and gain format
	localparam int ERROR_SCALE        = 10;
	localparam int GAIN_FRACTION_BITS = 16;

	// derived datapath widths
	localparam int DIFF_W  = IN_W + 1;
	localparam int SCALE_W = $clog2(ERROR_SCALE + 1) + 1;
	localparam int RAW_W   = DIFF_W + SCALE_W;
	localparam int WIDE_W  = (RAW_W > ERR_W) ? RAW_W : ERR_W;
	localparam int DLT_W   = ERR_W + 1;
	localparam int P_PW    = GAIN_W + ERR_W;
	localparam int I_PW    = GAIN_W + SUM_W;
	localparam int D_PW    = GAIN_W + DLT_W;
	localparam int P_W     = P_PW - GAIN_FRACTION_BITS;
	localparam int I_W     = I_PW - GAIN_FRACTION_BITS;
	localparam int D_W     = D_PW - GAIN_FRACTION_BITS;
	localparam int TOT_W   = ((P_W > D_W) ? P_W : D_W) + 2;

	// error saturation bounds
	localparam logic signed [WIDE_W-1:0] ERR_MAX =
		WIDE_W'((longint'(1) <<< (ERR_W - 1)) - 1);
	localparam logic signed [WIDE_W-1:0] ERR_MIN = -ERR_MAX - WIDE_W'(1);

	// register reset values
	localparam logic signed [LIM_W-1:0] INTEG_UPPER_RST = 16'sd1000;
	localparam logic signed [LIM_W-1:0] INTEG_LOWER_RST = -16'sd1000;
	localparam logic signed [LIM_W-1:0] OUT_UPPER_RST   = 16'sd5000;
	localparam logic signed [LIM_W-1:0] OUT_LOWER_RST   = -16'sd5000;

	typedef enum logic [IDX_W-1:0] {
		REG_PROP_GAIN   = 3'd0,
		REG_INTEG_GAIN  = 3'd1,
		REG_DERIV_GAIN  = 3'd2,
		REG_INTEG_UPPER = 3'd3,
		REG_INTEG_LOWER = 3'd4,
		REG_OUT_UPPER   = 3'd5,
		REG_OUT_LOWER   = 3'd6
	} reg_idx_t;

	typedef struct packed {
		logic signed [GAIN_W-1:0] prop_gain;
		logic signed [GAIN_W-1:0] integ_gain;
		logic signed [GAIN_W-1:0] deriv_gain;
		logic signed [LIM_W-1:0]  integ_upper;
		logic signed [LIM_W-1:0]  integ_lower;
		logic signed [LIM_W-1:0]  out_upper;
		logic signed [LIM_W-1:0]  out_lower;
	} cfg_t;

	typedef struct packed {
		logic signed [P_W-1:0]   p;
		logic signed [LIM_W-1:0] i;
		logic signed [D_W-1:0]   d;
	} terms_t;

endpackage

@@ hdl/positional_pid_antiwindup.sv @@
// positional pid controller with integral clamp, top level
//
//  channel  | handshake               | payload
//  ---------+-------------------------+-------------------------------
//  in       | in_valid / in_stall     | measured_value, target_value
//  out      | out_valid / out_stall   | drive_value
//  cfg      | cfg_we (write only)     | cfg_index, cfg_data
//
// one request per cycle while out_stall is low; each passes s1, s2 and the output register
// the error sum loop (add, 32x32 integral product, clamp) is combinational into err_sum_q
// arst_n clears the pipeline valids and the controller state and loads register defaults
// out_stall holds the output register; empty stages still fill, so in_stall rises
// only when every stage holds a request
`include "assert_macros.svh"
module positional_pid_antiwindup (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                in_valid,
	output logic                                in_stall,
	input  logic signed [ppa_pkg::IN_W-1:0]     measured_value,
	input  logic signed [ppa_pkg::IN_W-1:0]     target_value,
	output logic                                out_valid,
	input  logic                                out_stall,
	output logic signed [ppa_pkg::LIM_W-1:0]    drive_value,
	input  logic                                cfg_we,
	input  logic [ppa_pkg::IDX_W-1:0]           cfg_index,
	input  logic [ppa_pkg::CFG_W-1:0]           cfg_data
);

	ppa_pkg::cfg_t                     cfg_q;
	logic                              vld_s1;
	logic signed [ppa_pkg::IN_W-1:0]   meas_s1;
	logic signed [ppa_pkg::IN_W-1:0]   targ_s1;
	logic                              vld_s2;
	ppa_pkg::terms_t                   terms_s2;
	logic                              out_valid_q;
	logic signed [ppa_pkg::LIM_W-1:0]  drive_q;
	ppa_pkg::terms_t                   terms;
	logic signed [ppa_pkg::LIM_W-1:0]  drive;
	logic                              en1;
	logic                              en2;
	logic                              en3;

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.prop_gain   <= '0;
			cfg_q.integ_gain  <= '0;
			cfg_q.deriv_gain  <= '0;
			cfg_q.integ_upper <= ppa_pkg::INTEG_UPPER_RST;
			cfg_q.integ_lower <= ppa_pkg::INTEG_LOWER_RST;
			cfg_q.out_upper   <= ppa_pkg::OUT_UPPER_RST;
			cfg_q.out_lower   <= ppa_pkg::OUT_LOWER_RST;
		end else if (cfg_we) begin
			case (ppa_pkg::reg_idx_t'(cfg_index))
				ppa_pkg::REG_PROP_GAIN:   cfg_q.prop_gain   <= cfg_data;
				ppa_pkg::REG_INTEG_GAIN:  cfg_q.integ_gain  <= cfg_data;
				ppa_pkg::REG_DERIV_GAIN:  cfg_q.deriv_gain  <= cfg_data;
				ppa_pkg::REG_INTEG_UPPER: cfg_q.integ_upper <= cfg_data[ppa_pkg::LIM_W-1:0];
				ppa_pkg::REG_INTEG_LOWER: cfg_q.integ_lower <= cfg_data[ppa_pkg::LIM_W-1:0];
				ppa_pkg::REG_OUT_UPPER:   cfg_q.out_upper   <= cfg_data[ppa_pkg::LIM_W-1:0];
				ppa_pkg::REG_OUT_LOWER:   cfg_q.out_lower   <= cfg_data[ppa_pkg::LIM_W-1:0];
				default: ;
			endcase
		end
	end

	// stage enables, a stage moves when it is empty or the next one moves
	assign en3      = !out_valid_q || !out_stall;
	assign en2      = !vld_s2 || en3;
	assign en1      = !vld_s1 || en2;
	assign in_stall = !en1;

	// input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
		end else if (en1) begin
			vld_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (en1 && in_valid) begin
			meas_s1 <= measured_value;
			targ_s1 <= target_value;
		end
	end

	// terms and controller state
	ppa_term u_term (
		.clk    (clk),
		.arst_n (arst_n),
		.upd    (vld_s1 && en2),
		.cfg    (cfg_q),
		.meas   (meas_s1),
		.targ   (targ_s1),
		.terms  (terms)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s2 <= 1'b0;
		end else if (en2) begin
			vld_s2 <= vld_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (en2 && vld_s1) begin
			terms_s2 <= terms;
		end
	end

	// sum, clamp and output register
	ppa_mix u_mix (
		.terms (terms_s2),
		.cfg   (cfg_q),
		.drive (drive)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (en3) begin
			out_valid_q <= vld_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (en3 && vld_s2) begin
			drive_q <= drive;
		end
	end

	assign out_valid   = out_valid_q;
	assign drive_value = drive_q;

	// checks
	`ASSERT_HOLDS(a_stall_full, clk, arst_n, in_stall |-> vld_s1, "input stalled with stage one empty")
	`ASSERT_NEXT(a_term_moves, clk, arst_n, vld_s2 && !out_valid_q, out_valid_q, "terms did not move to output")
	`ASSERT_HOLDS(a_out_range, clk, arst_n, (out_valid_q && (cfg_q.out_lower <= cfg_q.out_upper)) |-> ((drive_q >= cfg_q.out_lower) && (drive_q <= cfg_q.out_upper)), "drive outside output limits")

endmodule

@@ hdl/ppa_term.sv @@
// error, error sum, the three gain products and the integral clamp
module ppa_term (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           upd,
	input  ppa_pkg::cfg_t                  cfg,
	input  logic signed [ppa_pkg::IN_W-1:0] meas,
	input  logic signed [ppa_pkg::IN_W-1:0] targ,
	output ppa_pkg::terms_t                terms
);

	logic signed [ppa_pkg::DIFF_W-1:0] diff;
	logic signed [ppa_pkg::WIDE_W-1:0] err_raw;
	logic signed [ppa_pkg::ERR_W-1:0]  err;
	logic signed [ppa_pkg::SUM_W:0]    sum_x;
	logic signed [ppa_pkg::SUM_W-1:0]  new_sum;
	logic signed [ppa_pkg::DLT_W-1:0]  dlt;
	logic signed [ppa_pkg::P_PW-1:0]   p_full;
	logic signed [ppa_pkg::I_PW-1:0]   i_full;
	logic signed [ppa_pkg::D_PW-1:0]   d_full;
	logic signed [ppa_pkg::I_W-1:0]    i_raw;
	logic signed [ppa_pkg::I_W-1:0]    i_up;
	logic signed [ppa_pkg::I_W-1:0]    i_lo;
	logic signed [ppa_pkg::I_W-1:0]    i_one;
	logic signed [ppa_pkg::I_W-1:0]    i_two;
	logic                              hit_up;
	logic                              hit_lo;
	logic signed [ppa_pkg::SUM_W-1:0]  err_sum_q;
	logic signed [ppa_pkg::ERR_W-1:0]  prev_err_q;

	// scaled error, saturated to the stored error width
	assign diff    = $signed({targ[ppa_pkg::IN_W-1], targ}) -
	                 $signed({meas[ppa_pkg::IN_W-1], meas});
	assign err_raw = $signed(ppa_pkg::WIDE_W'(diff)) *
	                 $signed(ppa_pkg::WIDE_W'(ppa_pkg::ERROR_SCALE));
	always_comb begin
		if (err_raw > ppa_pkg::ERR_MAX) begin
			err = ppa_pkg::ERR_MAX[ppa_pkg::ERR_W-1:0];
		end else if (err_raw < ppa_pkg::ERR_MIN) begin
			err = ppa_pkg::ERR_MIN[ppa_pkg::ERR_W-1:0];
		end else begin
			err = err_raw[ppa_pkg::ERR_W-1:0];
		end
	end

	// running sum with saturation at the sum limits
	assign sum_x = $signed({err_sum_q[ppa_pkg::SUM_W-1], err_sum_q}) +
	               $signed({{(ppa_pkg::SUM_W + 1 - ppa_pkg::ERR_W){err[ppa_pkg::ERR_W-1]}}, err});
	always_comb begin
		if (sum_x[ppa_pkg::SUM_W] != sum_x[ppa_pkg::SUM_W-1]) begin
			new_sum = sum_x[ppa_pkg::SUM_W] ? {1'b1, {(ppa_pkg::SUM_W-1){1'b0}}}
			                                : {1'b0, {(ppa_pkg::SUM_W-1){1'b1}}};
		end else begin
			new_sum = sum_x[ppa_pkg::SUM_W-1:0];
		end
	end

	// error change for the derivative term
	assign dlt = $signed({err[ppa_pkg::ERR_W-1], err}) -
	             $signed({prev_err_q[ppa_pkg::ERR_W-1], prev_err_q});

	// gain products, truncated toward minus infinity
	assign p_full = $signed(cfg.prop_gain) * $signed(err);
	assign i_full = $signed(cfg.integ_gain) * $signed(new_sum);
	assign d_full = $signed(cfg.deriv_gain) * $signed(dlt);
	assign i_raw  = i_full[ppa_pkg::I_PW-1:ppa_pkg::GAIN_FRACTION_BITS];

	// integral clamp: upper limit first, then lower
	assign i_up   = $signed({{(ppa_pkg::I_W-ppa_pkg::LIM_W){cfg.integ_upper[ppa_pkg::LIM_W-1]}},
	                         cfg.integ_upper});
	assign i_lo   = $signed({{(ppa_pkg::I_W-ppa_pkg::LIM_W){cfg.integ_lower[ppa_pkg::LIM_W-1]}},
	                         cfg.integ_lower});
	assign hit_up = i_raw > i_up;
	assign i_one  = hit_up ? i_up : i_raw;
	assign hit_lo = i_one < i_lo;
	assign i_two  = hit_lo ? i_lo : i_one;

	assign terms.p = p_full[ppa_pkg::P_PW-1:ppa_pkg::GAIN_FRACTION_BITS];
	assign terms.i = i_two[ppa_pkg::LIM_W-1:0];
	assign terms.d = d_full[ppa_pkg::D_PW-1:ppa_pkg::GAIN_FRACTION_BITS];

	// controller state, sum held back when the integral clamps
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			err_sum_q  <= '0;
			prev_err_q <= '0;
		end else if (upd) begin
			if (!(hit_up || hit_lo)) begin
				err_sum_q <= new_sum;
			end
			prev_err_q <= err;
		end
	end

endmodule

@@ hdl/ppa_mix.sv @@
// sum of the three terms and the output clamp
module ppa_mix (
	input  ppa_pkg::terms_t                 terms,
	input  ppa_pkg::cfg_t                   cfg,
	output logic signed [ppa_pkg::LIM_W-1:0] drive
);

	logic signed [ppa_pkg::TOT_W-1:0] total;
	logic signed [ppa_pkg::TOT_W-1:0] up_ext;
	logic signed [ppa_pkg::TOT_W-1:0] lo_ext;
	logic signed [ppa_pkg::TOT_W-1:0] t_one;
	logic signed [ppa_pkg::TOT_W-1:0] t_two;

	// widen and add
	assign total =
		$signed({{(ppa_pkg::TOT_W-ppa_pkg::P_W){terms.p[ppa_pkg::P_W-1]}}, terms.p}) +
		$signed({{(ppa_pkg::TOT_W-ppa_pkg::LIM_W){terms.i[ppa_pkg::LIM_W-1]}}, terms.i}) +
		$signed({{(ppa_pkg::TOT_W-ppa_pkg::D_W){terms.d[ppa_pkg::D_W-1]}}, terms.d});

	// upper limit first, lower limit wins when inverted
	assign up_ext = $signed({{(ppa_pkg::TOT_W-ppa_pkg::LIM_W){cfg.out_upper[ppa_pkg::LIM_W-1]}},
	                         cfg.out_upper});
	assign lo_ext = $signed({{(ppa_pkg::TOT_W-ppa_pkg::LIM_W){cfg.out_lower[ppa_pkg::LIM_W-1]}},
	                         cfg.out_lower});
	assign t_one  = (total > up_ext) ? up_ext : total;
	assign t_two  = (t_one < lo_ext) ? lo_ext : t_one;
	assign drive  = t_two[ppa_pkg::LIM_W-1:0];

endmodule
